/* sv/tlca_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package tlca_pkg;
   localparam int MAX_NODES_DEF = 1024;
   localparam int LEVELS_DEF = 10;
   localparam int NODE_W = 10;
   localparam int COUNT_W = 11;
   localparam int DEPTH_W = 10;
   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_BUILD = 2'd1;
   localparam logic [1:0] MODE_QUERY = 2'd2;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;
endpackage
`default_nettype wire

/* sv/tlca_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module tlca_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* sv/tree_lca_binary_lifting_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// load, bad index and spare items: pass through the done state before the next accept
// query: reads both depths, runs the equalize lift, ends early when it meets, else the full lift follows
// build: fills the table level by level, then measures every node's depth from it, up to the node count
// one item in flight at a time; every table read goes through the single read port
// a result waiting in the output register holds off the next item
// reset (synchronous) clears control state and sets node_count to 1024, memories untouched
module tree_lca_binary_lifting_core
   import tlca_pkg::*;
#(
   parameter int MAX_NODES = MAX_NODES_DEF,
   parameter int LEVELS = LEVELS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_mode,
   input  wire logic [NODE_W-1:0]  req_node_a,
   input  wire logic [NODE_W-1:0]  req_node_b,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [NODE_W-1:0]       rsp_ancestor_node,
   output logic [DEPTH_W-1:0]      rsp_ancestor_depth,
   output logic                    rsp_status,
   input  wire logic               csr_write,
   input  wire logic [COUNT_W-1:0] csr_wdata
);
   localparam int AW = $clog2(MAX_NODES);
   localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int TD = MAX_NODES * LEVELS;
   localparam int TW = $clog2(TD);
   localparam int CW = AW + 1;
   localparam logic [LW-1:0] LTOP = LW'(LEVELS - 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_BRD1  = 4'd1;  // build: read anc[v][lv-1]
   localparam logic [3:0] S_BRD2  = 4'd2;  // build: read anc[mid][lv-1]
   localparam logic [3:0] S_BWR   = 4'd3;  // build: write anc[v][lv]
   localparam logic [3:0] S_DRD   = 4'd4;  // depth: read anc[u][lv]
   localparam logic [3:0] S_DCHK  = 4'd5;
   localparam logic [3:0] S_QDA   = 4'd6;  // query: read depth a
   localparam logic [3:0] S_QDB   = 4'd7;
   localparam logic [3:0] S_QLRD  = 4'd8;  // equalize lift
   localparam logic [3:0] S_QARD  = 4'd9;  // read anc[a][lv]
   localparam logic [3:0] S_QBRD  = 4'd10; // read anc[b][lv]
   localparam logic [3:0] S_QCMP  = 4'd11;
   localparam logic [3:0] S_QFIN  = 4'd12; // read depth of answer
   localparam logic [3:0] S_DONE  = 4'd13;
   localparam logic [3:0] S_QDEP  = 4'd14;
   localparam logic [3:0] S_QEND  = 4'd15;

   logic [3:0] state_ff, state_in;
   logic [COUNT_W-1:0] count_ff;
   logic [CW-1:0] cnt;
   logic [AW-1:0] a_ff, a_in, b_ff, b_in, v_ff, v_in;
   logic [LW-1:0] lv_ff, lv_in;
   logic [DEPTH_W-1:0] d_ff, d_in, da_ff, da_in, diff_ff, diff_in;
   logic [NODE_W-1:0] x_ff, x_in;
   logic [NODE_W-1:0] o_node_ff, o_node_in;
   logic [DEPTH_W-1:0] o_dep_ff, o_dep_in;
   logic o_st_ff, o_st_in, o_v_ff, o_v_in;
   logic first_ff, first_in;

   logic t_we; logic [TW-1:0] t_wa, t_ra; logic [NODE_W-1:0] t_wd, t_rd;
   logic d_we; logic [AW-1:0] d_wa, d_ra; logic [DEPTH_W-1:0] d_wd, d_rd;

   tlca_ram #(.WIDTH(NODE_W), .DEPTH(TD)) u_anc (
      .clock(clock), .wr_en(t_we), .wr_addr(t_wa), .wr_data(t_wd),
      .rd_addr(t_ra), .rd_data(t_rd));
   tlca_ram #(.WIDTH(DEPTH_W), .DEPTH(MAX_NODES)) u_dep (
      .clock(clock), .wr_en(d_we), .wr_addr(d_wa), .wr_data(d_wd),
      .rd_addr(d_ra), .rd_data(d_rd));

   // table entry [node][level] lives at node*LEVELS+level
   function automatic logic [TW-1:0] tix(input logic [AW-1:0] n, input logic [LW-1:0] l);
      logic [TW+LW-1:0] p;
      p = (TW+LW)'(n) * (TW+LW)'(LEVELS) + (TW+LW)'(l);
      return p[TW-1:0];
   endfunction

   assign cnt = (count_ff > COUNT_W'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(count_ff);

   logic a_bad, b_bad;
   assign a_bad = (CW'(req_node_a) >= cnt) || (NODE_W > AW && (req_node_a >> AW) != 0);
   assign b_bad = (CW'(req_node_b) >= cnt) || (NODE_W > AW && (req_node_b >> AW) != 0);

   assign req_ready = (state_ff == S_IDLE) && !o_v_ff;
   assign rsp_valid = o_v_ff;
   assign rsp_ancestor_node = o_node_ff;
   assign rsp_ancestor_depth = o_dep_ff;
   assign rsp_status = o_st_ff;

   logic [AW-1:0] tn;
   assign tn = t_rd[AW-1:0];

   always_comb begin
      state_in = state_ff; a_in = a_ff; b_in = b_ff; v_in = v_ff; lv_in = lv_ff;
      d_in = d_ff; da_in = da_ff; diff_in = diff_ff; x_in = x_ff; first_in = first_ff;
      o_node_in = o_node_ff; o_dep_in = o_dep_ff; o_st_in = o_st_ff;
      o_v_in = o_v_ff && !rsp_ready;
      t_we = 1'b0; t_wa = '0; t_wd = '0; t_ra = tix(a_ff, lv_ff);
      d_we = 1'b0; d_wa = v_ff; d_wd = d_ff; d_ra = a_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               a_in = req_node_a[AW-1:0]; b_in = req_node_b[AW-1:0];
               o_node_in = '0; o_dep_in = '0; o_st_in = 1'b0;
               case (req_mode)
                  MODE_LOAD: begin
                     if (a_bad || b_bad) o_st_in = 1'b1;
                     else begin
                        t_we = 1'b1; t_wa = tix(req_node_a[AW-1:0], '0);
                        t_wd = req_node_b;
                     end
                     state_in = S_DONE;
                  end
                  MODE_BUILD: begin
                     t_we = 1'b1; t_wa = '0; t_wd = '0;
                     v_in = '0;
                     if (LEVELS > 1) begin lv_in = LW'(1); state_in = S_BRD1; end
                     else begin lv_in = LTOP; d_in = '0; state_in = S_DRD; end
                  end
                  MODE_QUERY: begin
                     if (a_bad || b_bad) begin o_st_in = 1'b1; state_in = S_DONE; end
                     else state_in = S_QDA;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_BRD1: begin
            t_ra = tix(v_ff, lv_ff - LW'(1)); state_in = S_BRD2;
         end
         S_BRD2: begin
            t_ra = tix(tn, lv_ff - LW'(1)); state_in = S_BWR;
         end
         S_BWR: begin
            t_we = 1'b1; t_wa = tix(v_ff, lv_ff); t_wd = t_rd;
            if (CW'(v_ff) + CW'(1) >= cnt) begin
               v_in = '0;
               if (lv_ff == LTOP) begin
                  lv_in = LTOP; d_in = '0; a_in = '0; state_in = S_DRD;
               end else begin lv_in = lv_ff + LW'(1); state_in = S_BRD1; end
            end else begin v_in = v_ff + AW'(1); state_in = S_BRD1; end
         end
         // depth walk: a_ff is u, v_ff the node being measured
         S_DRD: begin
            if (v_ff == '0) begin
               d_we = 1'b1; d_wd = '0; state_in = S_DCHK; first_in = 1'b1;
            end else begin
               t_ra = tix(a_ff, lv_ff); state_in = S_DCHK; first_in = 1'b0;
            end
         end
         S_DCHK: begin
            if (first_ff) begin
               d_in = '0; lv_in = LTOP;
               if (CW'(v_ff) + CW'(1) >= cnt) state_in = S_DONE;
               else begin v_in = v_ff + AW'(1); a_in = v_ff + AW'(1); state_in = S_DRD; end
            end else begin
               logic [DEPTH_W-1:0] dn;
               dn = d_ff;
               if (t_rd != '0) begin
                  a_in = tn; dn = d_ff + DEPTH_W'(1 << lv_ff);
               end
               if (lv_ff == '0) begin
                  d_we = 1'b1; d_wd = dn + DEPTH_W'(1);
                  d_in = '0; lv_in = LTOP;
                  if (CW'(v_ff) + CW'(1) >= cnt) state_in = S_DONE;
                  else begin v_in = v_ff + AW'(1); a_in = v_ff + AW'(1); state_in = S_DRD; end
               end else begin
                  d_in = dn; lv_in = lv_ff - LW'(1); state_in = S_DRD;
               end
            end
         end
         S_QDA: begin d_ra = a_ff; state_in = S_QDB; end
         S_QDB: begin d_ra = b_ff; da_in = d_rd; state_in = S_QDEP; end
         S_QDEP: begin
            if (da_ff < d_rd) begin
               a_in = b_ff; b_in = a_ff; diff_in = d_rd - da_ff;
            end else diff_in = da_ff - d_rd;
            lv_in = '0; first_in = 1'b1; state_in = S_QLRD;
         end
         // equalize: first_ff marks a cycle with no read pending
         S_QLRD: begin
            logic [AW-1:0] an;
            an = a_ff;
            if (!first_ff) an = tn;
            a_in = an;
            if (diff_ff[lv_ff]) t_ra = tix(an, lv_ff);
            // step bookkeeping
            first_in = !diff_ff[lv_ff];
            x_in = '0;
            if (lv_ff == LTOP) begin
               x_in = NODE_W'(diff_ff[lv_ff]);
               state_in = S_QEND;
            end else lv_in = lv_ff + LW'(1);
         end
         S_QEND: begin
            logic [AW-1:0] an;
            an = (x_ff != '0) ? tn : a_ff;
            a_in = an;
            if (an == b_ff) begin
               // answer known; issue its depth read
               o_node_in = NODE_W'(an); d_ra = an; first_in = 1'b1; state_in = S_QFIN;
            end else begin lv_in = LTOP; state_in = S_QARD; end
         end
         S_QARD: begin t_ra = tix(a_ff, lv_ff); state_in = S_QBRD; end
         S_QBRD: begin t_ra = tix(b_ff, lv_ff); x_in = t_rd; state_in = S_QCMP; end
         S_QCMP: begin
            logic [AW-1:0] an;
            an = a_ff;
            if (x_ff != t_rd) begin an = x_ff[AW-1:0]; a_in = an; b_in = tn; end
            if (lv_ff == '0) begin
               // answer is anc[a][0]; read it, then its depth
               t_ra = tix(an, '0); first_in = 1'b0; state_in = S_QFIN;
               o_node_in = '1;
            end else begin lv_in = lv_ff - LW'(1); state_in = S_QARD; end
         end
         S_QFIN: begin
            if (o_node_ff == '1 && !first_ff) begin
               o_node_in = t_rd; d_ra = tn; first_in = 1'b1;
            end else begin
               o_dep_in = d_rd; o_v_in = 1'b1; state_in = S_IDLE;
            end
         end
         S_DONE: begin o_v_in = 1'b1; state_in = S_IDLE; end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= COUNT_RESET; o_v_ff <= 1'b0; first_ff <= 1'b0;
      end else begin
         state_ff <= state_in; o_v_ff <= o_v_in; first_ff <= first_in;
         if (csr_write) count_ff <= csr_wdata;
      end
      a_ff <= a_in; b_ff <= b_in; v_ff <= v_in; lv_ff <= lv_in; d_ff <= d_in;
      da_ff <= da_in; diff_ff <= diff_in; x_ff <= x_in;
      o_node_ff <= o_node_in; o_dep_ff <= o_dep_in; o_st_ff <= o_st_in;
   end

   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("accept while result pending");
   a_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready) else $error("engine took two items");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_ancestor_node)))
      else $error("result lost");
endmodule
`default_nettype wire
